@@ rtl/core/mot_trip_pkg.sv @@
// Shared types, widths and constants for the motor overcurrent trip core.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package mot_trip_pkg;

    localparam int SAMPLES_PER_CHECK = 40;
    localparam int MS_PER_DOSE       = 10000;
    localparam int MAX_DOSE          = 9;

    localparam int CODE_W      = 10;
    localparam int SUM_W       = 16;
    localparam int COUNT_W     = 6;
    localparam int RUN_W       = 17;
    localparam int DELAY_W     = 16;
    localparam int DOSE_W      = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // The block average uses an exact reciprocal multiply instead of a divider.
    localparam int     DIV_SHIFT  = SUM_W + $clog2(SAMPLES_PER_CHECK);
    localparam longint DIV_MULT   = ((longint'(1) << DIV_SHIFT) + SAMPLES_PER_CHECK - 1)
                                    / SAMPLES_PER_CHECK;
    localparam int     DIV_MULT_W = SUM_W + 1;
    localparam int     PROD_W     = SUM_W + DIV_MULT_W;

    localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(SAMPLES_PER_CHECK - 1);
    localparam logic [DELAY_W-1:0] DELAY_MAX  = {DELAY_W{1'b1}};

    localparam logic [CODE_W-1:0]  ZERO_CODE_RST  = CODE_W'(512);
    localparam logic [CODE_W-1:0]  LIMIT_CODE_RST = CODE_W'(81);
    localparam logic [DELAY_W-1:0] TRIP_DELAY_RST = DELAY_W'(300);
    localparam logic [DOSE_W-1:0]  DOSE_UNITS_RST = DOSE_W'(4);

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_START  = 2'd2,
        CMD_STOP   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ZERO_CODE  = 2'd0,
        REG_LIMIT_CODE = 2'd1,
        REG_TRIP_DELAY = 2'd2,
        REG_DOSE_UNITS = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic              complete;
        logic              over;
        logic [CODE_W-1:0] average;
    } block_result_t;

    function automatic logic [RUN_W-1:0] run_target(input logic [DOSE_W-1:0] dose);
        logic [DOSE_W-1:0] d;
        d = (dose > DOSE_W'(MAX_DOSE)) ? DOSE_W'(MAX_DOSE) : dose;
        return RUN_W'(int'(d) * MS_PER_DOSE);
    endfunction

endpackage

@@ rtl/core/mot_trip_measure.sv @@
// Current sample accumulator: sums samples in blocks, forms the block average
// and the overcurrent decision. Depends on mot_trip_pkg.
`timescale 1ns / 1ps

module mot_trip_measure (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_en,
    input  logic                                clear,
    input  logic [mot_trip_pkg::CODE_W-1:0]     sample_code,
    input  logic [mot_trip_pkg::CODE_W-1:0]     zero_code,
    input  logic [mot_trip_pkg::CODE_W-1:0]     limit_code,
    output mot_trip_pkg::block_result_t         blk
);

    logic [mot_trip_pkg::SUM_W-1:0]   sum_reg;
    logic [mot_trip_pkg::SUM_W-1:0]   sum_next;
    logic [mot_trip_pkg::COUNT_W-1:0] count_reg;
    logic [mot_trip_pkg::COUNT_W-1:0] count_next;
    logic [mot_trip_pkg::SUM_W-1:0]   acc_sum;
    logic [mot_trip_pkg::SUM_W-1:0]   base;
    logic [mot_trip_pkg::SUM_W-1:0]   lim;
    logic [mot_trip_pkg::SUM_W-1:0]   diff;
    logic [mot_trip_pkg::PROD_W-1:0]  prod;
    logic [mot_trip_pkg::PROD_W-1:0]  quot;
    logic                             last;

    always_comb
    begin
        acc_sum = sum_reg + mot_trip_pkg::SUM_W'(sample_code);
        last    = (count_reg == mot_trip_pkg::LAST_COUNT);
        base    = mot_trip_pkg::SUM_W'(mot_trip_pkg::SUM_W'(zero_code)
                  * mot_trip_pkg::SUM_W'(mot_trip_pkg::SAMPLES_PER_CHECK));
        lim     = mot_trip_pkg::SUM_W'(mot_trip_pkg::SUM_W'(limit_code)
                  * mot_trip_pkg::SUM_W'(mot_trip_pkg::SAMPLES_PER_CHECK));
        diff    = (acc_sum >= base) ? (acc_sum - base) : (base - acc_sum);
        prod    = mot_trip_pkg::PROD_W'(acc_sum)
                  * mot_trip_pkg::PROD_W'(mot_trip_pkg::DIV_MULT);
        quot    = prod >> mot_trip_pkg::DIV_SHIFT;

        blk.complete = sample_en && last;
        blk.over     = (diff >= lim);
        blk.average  = quot[mot_trip_pkg::CODE_W-1:0];
    end

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (clear)
        begin
            sum_next   = '0;
            count_next = '0;
        end
        else if (sample_en)
        begin
            if (last)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = acc_sum;
                count_next = count_reg + mot_trip_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/core/mot_trip_ctrl.sv @@
// Run controller: motor state, run timer, overcurrent persistence timer and
// the latched fault. Depends on mot_trip_pkg.
`timescale 1ns / 1ps

module mot_trip_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_fire,
    input  mot_trip_pkg::cmd_t                  cmd,
    input  mot_trip_pkg::block_result_t         blk,
    input  logic [mot_trip_pkg::DELAY_W-1:0]    trip_delay_ms,
    input  logic [mot_trip_pkg::DOSE_W-1:0]     dose_units,
    output logic                                sample_en,
    output logic                                start_ok,
    output logic                                running,
    output logic                                fault_latched,
    output logic                                motor_on_next,
    output logic                                fault_next,
    output logic                                done
);

    logic                               running_reg;
    logic                               running_next;
    logic                               fault_reg;
    logic                               fault_reg_next;
    logic [mot_trip_pkg::RUN_W-1:0]     run_elapsed_reg;
    logic [mot_trip_pkg::RUN_W-1:0]     run_elapsed_next;
    logic                               over_pending_reg;
    logic                               over_pending_next;
    logic [mot_trip_pkg::DELAY_W-1:0]   over_elapsed_reg;
    logic [mot_trip_pkg::DELAY_W-1:0]   over_elapsed_next;
    logic [mot_trip_pkg::RUN_W-1:0]     target;
    logic [mot_trip_pkg::RUN_W-1:0]     run_inc;

    assign sample_en = in_fire && (cmd == mot_trip_pkg::CMD_SAMPLE) && running_reg;

    always_comb
    begin
        target            = mot_trip_pkg::run_target(dose_units);
        run_inc           = run_elapsed_reg + mot_trip_pkg::RUN_W'(1);
        running_next      = running_reg;
        fault_reg_next    = fault_reg;
        run_elapsed_next  = run_elapsed_reg;
        over_pending_next = over_pending_reg;
        over_elapsed_next = over_elapsed_reg;
        done              = 1'b0;
        start_ok          = 1'b0;

        if (in_fire)
        begin
            case (cmd)
                mot_trip_pkg::CMD_SAMPLE:
                begin
                    if (blk.complete)
                    begin
                        if (blk.over)
                        begin
                            over_pending_next = 1'b1;
                            if (!over_pending_reg)
                            begin
                                over_elapsed_next = '0;
                            end
                            if ((over_pending_reg ? over_elapsed_reg : '0) >= trip_delay_ms)
                            begin
                                running_next   = 1'b0;
                                fault_reg_next = 1'b1;
                            end
                        end
                        else
                        begin
                            over_pending_next = 1'b0;
                            over_elapsed_next = '0;
                        end
                    end
                end
                mot_trip_pkg::CMD_TICK:
                begin
                    if (running_reg)
                    begin
                        if (over_pending_reg && (over_elapsed_reg != mot_trip_pkg::DELAY_MAX))
                        begin
                            over_elapsed_next = over_elapsed_reg
                                                + mot_trip_pkg::DELAY_W'(1);
                        end
                        run_elapsed_next = run_inc;
                        if (run_inc >= target)
                        begin
                            running_next = 1'b0;
                            done         = 1'b1;
                        end
                    end
                end
                mot_trip_pkg::CMD_START:
                begin
                    if (!fault_reg)
                    begin
                        start_ok          = 1'b1;
                        over_pending_next = 1'b0;
                        over_elapsed_next = '0;
                        run_elapsed_next  = '0;
                        if (target == '0)
                        begin
                            running_next = 1'b0;
                            done         = 1'b1;
                        end
                        else
                        begin
                            running_next = 1'b1;
                        end
                    end
                end
                mot_trip_pkg::CMD_STOP:
                begin
                    running_next = 1'b0;
                end
                default:
                begin
                    running_next = running_reg;
                end
            endcase
        end

        running       = running_reg;
        fault_latched = fault_reg;
        motor_on_next = running_next;
        fault_next    = fault_reg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg      <= 1'b0;
            fault_reg        <= 1'b0;
            run_elapsed_reg  <= '0;
            over_pending_reg <= 1'b0;
            over_elapsed_reg <= '0;
        end
        else
        begin
            running_reg      <= running_next;
            fault_reg        <= fault_reg_next;
            run_elapsed_reg  <= run_elapsed_next;
            over_pending_reg <= over_pending_next;
            over_elapsed_reg <= over_elapsed_next;
        end
    end

endmodule

@@ rtl/core/motor_overcurrent_trip_core.sv @@
// Motor run controller with latched overcurrent trip: top level.
// Instantiates mot_trip_measure and mot_trip_ctrl; depends on mot_trip_pkg.
//
// Usage:
// The input channel (in_valid, in_ready, cmd, sample_code) carries current
// samples, millisecond ticks, start and stop commands. Every accepted input
// transfer yields exactly one result transfer on the output channel
// (out_valid, out_ready, motor_on, fault, feed_done, average_valid,
// average_code), in order.
// The result is written to the output register at the edge that takes the
// input transfer. Throughput is one item per cycle while the receiver does
// not stall; all state updates for an item are registered with its result.
// When the receiver stalls, the result register holds and in_ready falls, so
// at most one result waits; a result leaving frees the register in the same
// cycle that a new item is taken.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at the
// next edge; the user must make them only while no transfer is in flight,
// which the block does not check. Reset clears the motor, the fault, all
// timers and the sample accumulator, and loads the default register values.
`timescale 1ns / 1ps

module motor_overcurrent_trip_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [mot_trip_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mot_trip_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [1:0]                              cmd,
    input  logic [mot_trip_pkg::CODE_W-1:0]         sample_code,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    motor_on,
    output logic                                    fault,
    output logic                                    feed_done,
    output logic                                    average_valid,
    output logic [mot_trip_pkg::CODE_W-1:0]         average_code
);

    logic [mot_trip_pkg::CODE_W-1:0]   zero_code_reg;
    logic [mot_trip_pkg::CODE_W-1:0]   limit_code_reg;
    logic [mot_trip_pkg::DELAY_W-1:0]  trip_delay_reg;
    logic [mot_trip_pkg::DOSE_W-1:0]   dose_units_reg;

    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              motor_on_reg;
    logic                              fault_out_reg;
    logic                              feed_done_reg;
    logic                              average_valid_reg;
    logic [mot_trip_pkg::CODE_W-1:0]   average_code_reg;

    logic                              in_fire;
    mot_trip_pkg::cmd_t                cmd_in;
    mot_trip_pkg::block_result_t       blk;
    logic                              sample_en;
    logic                              start_ok;
    logic                              running;
    logic                              fault_latched;
    logic                              motor_on_next;
    logic                              fault_next;
    logic                              done;

    assign cmd_in   = mot_trip_pkg::cmd_t'(cmd);
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_code_reg  <= mot_trip_pkg::ZERO_CODE_RST;
            limit_code_reg <= mot_trip_pkg::LIMIT_CODE_RST;
            trip_delay_reg <= mot_trip_pkg::TRIP_DELAY_RST;
            dose_units_reg <= mot_trip_pkg::DOSE_UNITS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (mot_trip_pkg::cfg_index_t'(cfg_index))
                mot_trip_pkg::REG_ZERO_CODE:
                    zero_code_reg  <= cfg_data[mot_trip_pkg::CODE_W-1:0];
                mot_trip_pkg::REG_LIMIT_CODE:
                    limit_code_reg <= cfg_data[mot_trip_pkg::CODE_W-1:0];
                mot_trip_pkg::REG_TRIP_DELAY:
                    trip_delay_reg <= cfg_data[mot_trip_pkg::DELAY_W-1:0];
                mot_trip_pkg::REG_DOSE_UNITS:
                    dose_units_reg <= cfg_data[mot_trip_pkg::DOSE_W-1:0];
                default:
                    dose_units_reg <= dose_units_reg;
            endcase
        end
    end

    mot_trip_measure u_measure (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_en   (sample_en),
        .clear       (start_ok),
        .sample_code (sample_code),
        .zero_code   (zero_code_reg),
        .limit_code  (limit_code_reg),
        .blk         (blk)
    );

    mot_trip_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .cmd           (cmd_in),
        .blk           (blk),
        .trip_delay_ms (trip_delay_reg),
        .dose_units    (dose_units_reg),
        .sample_en     (sample_en),
        .start_ok      (start_ok),
        .running       (running),
        .fault_latched (fault_latched),
        .motor_on_next (motor_on_next),
        .fault_next    (fault_next),
        .done          (done)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motor_on_reg      <= 1'b0;
            fault_out_reg     <= 1'b0;
            feed_done_reg     <= 1'b0;
            average_valid_reg <= 1'b0;
            average_code_reg  <= '0;
        end
        else if (in_fire)
        begin
            motor_on_reg      <= motor_on_next;
            fault_out_reg     <= fault_next;
            feed_done_reg     <= done;
            average_valid_reg <= blk.complete;
            average_code_reg  <= blk.complete ? blk.average : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign motor_on      = motor_on_reg;
    assign fault         = fault_out_reg;
    assign feed_done     = feed_done_reg;
    assign average_valid = average_valid_reg;
    assign average_code  = average_code_reg;

`ifndef ASSERT_OFF
    a_fault_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        fault_latched |=> fault_latched)
        else $error("Latched fault cleared without reset.");

    a_fault_stops_motor: assert property (@(posedge clk) disable iff (!rst_n)
        fault_latched |-> !running)
        else $error("Motor running while a fault is latched.");

    a_average_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !average_valid) |-> (average_code == '0))
        else $error("Average code nonzero without a completed block.");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("Input stalled while the result register is empty.");
`endif

endmodule
